>>> src/mvt_pkg.sv
// ----------------------------------------------------------------------------
// mvt_pkg
// Shared widths and types for the 4x4 matrix by 4-vector transform core.
// ----------------------------------------------------------------------------
package mvt_pkg;

	localparam int ELEM_W    = 32;            // one matrix element / component
	localparam int REG_W     = 64;            // one configuration register
	localparam int NUM_REGS  = 8;             // two elements per register
	localparam int CFG_IDX_W = 4;             // index port, wider than the file
	localparam int DIM       = 4;
	localparam int PROD_W    = 2 * ELEM_W;    // exact product
	localparam int PAIR_W    = PROD_W + 1;    // sum of two products
	localparam int SUM_W     = PROD_W + 3;    // four products plus rounding

	typedef logic signed [ELEM_W-1:0] elem_t;
	typedef logic [REG_W-1:0] cfg_reg_t;

	// matrix as [column][row], each element a raw two's complement pattern
	typedef logic [DIM-1:0][DIM-1:0][ELEM_W-1:0] mat_t;
	// input vector components [component]
	typedef logic [DIM-1:0][ELEM_W-1:0] vec_t;
	// products as [row][column]
	typedef logic [DIM-1:0][DIM-1:0][PROD_W-1:0] prod_t;
	// pair sums as [row]
	typedef logic [DIM-1:0][PAIR_W-1:0] pair_t;
	// full sums as [row]
	typedef logic [DIM-1:0][SUM_W-1:0] sum_t;

	localparam elem_t ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
	localparam elem_t ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

endpackage

>>> src/mvt_if.sv
// ----------------------------------------------------------------------------
// mvt_if
// Valid/ready channels of the transform core: vector in, result out, and
// the matrix register write port.
// ----------------------------------------------------------------------------
interface mvt_vec_if;
	logic          valid;
	logic          ready;
	mvt_pkg::elem_t in_x;
	mvt_pkg::elem_t in_y;
	mvt_pkg::elem_t in_z;
	mvt_pkg::elem_t in_w;

	modport source (output valid, output in_x, output in_y, output in_z, output in_w,
		input ready);
	modport sink (input valid, input in_x, input in_y, input in_z, input in_w,
		output ready);
endinterface

interface mvt_res_if;
	logic          valid;
	logic          ready;
	mvt_pkg::elem_t out_x;
	mvt_pkg::elem_t out_y;
	mvt_pkg::elem_t out_z;
	mvt_pkg::elem_t out_w;
	logic          saturated;

	modport source (output valid, output out_x, output out_y, output out_z, output out_w,
		output saturated, input ready);
	modport sink (input valid, input out_x, input out_y, input out_z, input out_w,
		input saturated, output ready);
endinterface

interface mvt_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [mvt_pkg::CFG_IDX_W-1:0]    index;
	mvt_pkg::cfg_reg_t                data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/mvt_cfg.sv
// ----------------------------------------------------------------------------
// mvt_cfg
// Matrix register file: eight 64-bit registers, two elements each, reset
// to the identity matrix.
// ----------------------------------------------------------------------------
module mvt_cfg #(
	parameter int FRAC_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	mvt_cfg_if.sink        cfg,
	output mvt_pkg::mat_t  mat
);

	localparam logic [mvt_pkg::ELEM_W-1:0] ONE = mvt_pkg::ELEM_W'(1) << FRAC_BITS;
	localparam logic [mvt_pkg::ELEM_W-1:0] ZERO = '0;

	mvt_pkg::cfg_reg_t regs_q [mvt_pkg::NUM_REGS];

	assign cfg.ready = 1'b1;

	// register writes; out-of-range indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q[0] <= {ZERO, ONE};
			regs_q[1] <= '0;
			regs_q[2] <= {ONE, ZERO};
			regs_q[3] <= '0;
			regs_q[4] <= '0;
			regs_q[5] <= {ZERO, ONE};
			regs_q[6] <= '0;
			regs_q[7] <= {ONE, ZERO};
		end else if (cfg.valid && cfg.ready &&
				cfg.index < mvt_pkg::CFG_IDX_W'(mvt_pkg::NUM_REGS)) begin
			regs_q[cfg.index[$clog2(mvt_pkg::NUM_REGS)-1:0]] <= cfg.data;
		end
	end

	// unpack to [column][row]
	for (genvar c = 0; c < mvt_pkg::DIM; c++) begin : g_col
		for (genvar r = 0; r < mvt_pkg::DIM; r++) begin : g_row
			assign mat[c][r] = regs_q[2*c + r/2][(r%2)*mvt_pkg::ELEM_W +: mvt_pkg::ELEM_W];
		end
	end

endmodule

>>> src/mvt_mul.sv
// ----------------------------------------------------------------------------
// mvt_mul
// Stage 1: sixteen signed 32x32 products, one per matrix element.
// ----------------------------------------------------------------------------
module mvt_mul (
	input  logic           clk,
	input  logic           load,
	input  mvt_pkg::mat_t  mat,
	input  mvt_pkg::vec_t  vec,
	output mvt_pkg::prod_t prod_s1
);

	mvt_pkg::prod_t prod;

	// element of column j, row r times component j
	for (genvar r = 0; r < mvt_pkg::DIM; r++) begin : g_row
		for (genvar j = 0; j < mvt_pkg::DIM; j++) begin : g_col
			assign prod[r][j] = mvt_pkg::PROD_W'($signed(mat[j][r]) * $signed(vec[j]));
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			prod_s1 <= prod;
		end
	end

endmodule

>>> src/mvt_sum.sv
// ----------------------------------------------------------------------------
// mvt_sum
// Stages 2 and 3: per-row adder tree over the four products, with the
// half-LSB rounding constant folded into the final add.
// ----------------------------------------------------------------------------
module mvt_sum #(
	parameter int FRAC_BITS = 16
) (
	input  logic           clk,
	input  logic           load_s2,
	input  logic           load_s3,
	input  mvt_pkg::prod_t prod_s1,
	output mvt_pkg::sum_t  sum_s3
);

	localparam logic signed [mvt_pkg::SUM_W-1:0] HALF =
		mvt_pkg::SUM_W'(1) << (FRAC_BITS - 1);

	mvt_pkg::pair_t lo_s2;
	mvt_pkg::pair_t hi_s2;
	mvt_pkg::pair_t lo_d;
	mvt_pkg::pair_t hi_d;
	mvt_pkg::sum_t  sum_d;

	for (genvar r = 0; r < mvt_pkg::DIM; r++) begin : g_row
		// pair sums, sign extended by one bit
		assign lo_d[r] = mvt_pkg::PAIR_W'($signed(prod_s1[r][0]))
			+ mvt_pkg::PAIR_W'($signed(prod_s1[r][1]));
		assign hi_d[r] = mvt_pkg::PAIR_W'($signed(prod_s1[r][2]))
			+ mvt_pkg::PAIR_W'($signed(prod_s1[r][3]));
		// full sum plus rounding constant
		assign sum_d[r] = mvt_pkg::SUM_W'($signed(lo_s2[r]))
			+ mvt_pkg::SUM_W'($signed(hi_s2[r])) + HALF;
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			lo_s2 <= lo_d;
			hi_s2 <= hi_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s3) begin
			sum_s3 <= sum_d;
		end
	end

endmodule

>>> src/mvt_sat.sv
// ----------------------------------------------------------------------------
// mvt_sat
// Stage 4: arithmetic shift by the fraction width and saturation to the
// signed 32-bit range, into the output register.
// ----------------------------------------------------------------------------
module mvt_sat #(
	parameter int FRAC_BITS = 16
) (
	input  logic          clk,
	input  logic          load,
	input  mvt_pkg::sum_t sum_s3,
	output mvt_pkg::vec_t res_s4,
	output logic          sat_s4
);

	localparam int SH_W = mvt_pkg::SUM_W - FRAC_BITS;

	mvt_pkg::vec_t        res_d;
	logic [mvt_pkg::DIM-1:0] clip;

	for (genvar r = 0; r < mvt_pkg::DIM; r++) begin : g_row
		logic [SH_W-1:0] sh;
		logic            fits;

		assign sh = sum_s3[r][mvt_pkg::SUM_W-1:FRAC_BITS];
		// in range when every bit above the 32-bit sign agrees with it
		assign fits = (&sh[SH_W-1:mvt_pkg::ELEM_W-1]) || !(|sh[SH_W-1:mvt_pkg::ELEM_W-1]);
		assign clip[r] = !fits;
		assign res_d[r] = fits ? sh[mvt_pkg::ELEM_W-1:0]
			: (sh[SH_W-1] ? mvt_pkg::ELEM_MIN : mvt_pkg::ELEM_MAX);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s4 <= res_d;
			sat_s4 <= |clip;
		end
	end

endmodule

>>> src/matrix_vector_transform_core.sv
// ----------------------------------------------------------------------------
// matrix_vector_transform_core
// Q-format 4x4 matrix times 4-vector, rounded and saturated per component.
//
//   channel | dir | payload                                   | handshake
//   --------+-----+-------------------------------------------+-------------
//   vec     | in  | in_x, in_y, in_z, in_w                    | valid/ready
//   res     | out | out_x, out_y, out_z, out_w, saturated      | valid/ready
//   cfg     | in  | index (register 0..7), data (64 bits)      | valid/ready
//
// One vector per cycle while the output is not stalled, through four stages
// (multiply, pair add, final add with rounding, shift and saturate).
// Reset clears all stage valids and loads the identity matrix.
// Each stage refills as soon as it is empty or moving on, so a stall at the
// output only blocks input once all four stages hold an item.
// cfg is always ready.
// ----------------------------------------------------------------------------
module matrix_vector_transform_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	mvt_vec_if.sink  vec,
	mvt_res_if.source res,
	mvt_cfg_if.sink  cfg
);

	mvt_pkg::mat_t  mat;
	mvt_pkg::vec_t  vin;
	mvt_pkg::prod_t prod_s1;
	mvt_pkg::sum_t  sum_s3;
	mvt_pkg::vec_t  res_s4;
	logic           sat_s4;

	logic v_s1, v_s2, v_s3, v_s4;
	logic ld1, ld2, ld3, ld4;

	// stage load enables: a stage loads when empty or when it drains
	assign ld4 = !v_s4 || res.ready;
	assign ld3 = !v_s3 || ld4;
	assign ld2 = !v_s2 || ld3;
	assign ld1 = !v_s1 || ld2;

	assign vec.ready = ld1;

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (ld1) v_s1 <= vec.valid;
			if (ld2) v_s2 <= v_s1;
			if (ld3) v_s3 <= v_s2;
			if (ld4) v_s4 <= v_s3;
		end
	end

	assign vin = {vec.in_w, vec.in_z, vec.in_y, vec.in_x};

	mvt_cfg #(.FRAC_BITS(FRAC_BITS)) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.mat    (mat)
	);

	mvt_mul u_mul (
		.clk     (clk),
		.load    (ld1 && vec.valid),
		.mat     (mat),
		.vec     (vin),
		.prod_s1 (prod_s1)
	);

	mvt_sum #(.FRAC_BITS(FRAC_BITS)) u_sum (
		.clk     (clk),
		.load_s2 (ld2 && v_s1),
		.load_s3 (ld3 && v_s2),
		.prod_s1 (prod_s1),
		.sum_s3  (sum_s3)
	);

	mvt_sat #(.FRAC_BITS(FRAC_BITS)) u_sat (
		.clk    (clk),
		.load   (ld4 && v_s3),
		.sum_s3 (sum_s3),
		.res_s4 (res_s4),
		.sat_s4 (sat_s4)
	);

	// output register drives the result channel
	assign res.valid     = v_s4;
	assign res.out_x     = res_s4[0];
	assign res.out_y     = res_s4[1];
	assign res.out_z     = res_s4[2];
	assign res.out_w     = res_s4[3];
	assign res.saturated = sat_s4;

	// occupancy follows accepted inputs and delivered results
	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ($countones({v_s1, v_s2, v_s3, v_s4}) ==
			$past($countones({v_s1, v_s2, v_s3, v_s4}))
			+ $past(int'(vec.valid && vec.ready)) - $past(int'(res.valid && res.ready))))
		else $error("pipeline occupancy mismatch");

	// input is only held off when every stage is full
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!(v_s1 && v_s2 && v_s3 && v_s4) |-> vec.ready)
		else $error("input stalled with a free stage");

	// a clipped result carries a limit value in some component
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.saturated) |->
			(res.out_x == mvt_pkg::ELEM_MAX || res.out_x == mvt_pkg::ELEM_MIN ||
			res.out_y == mvt_pkg::ELEM_MAX || res.out_y == mvt_pkg::ELEM_MIN ||
			res.out_z == mvt_pkg::ELEM_MAX || res.out_z == mvt_pkg::ELEM_MIN ||
			res.out_w == mvt_pkg::ELEM_MAX || res.out_w == mvt_pkg::ELEM_MIN))
		else $error("saturated flag without a limit value");

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 4x4 matrix by 4-vector transform core. Loads
// several matrices (reset identity, all-minimum, all-maximum, one-half
// diagonal, random), streams directed and random vectors under bursty input
// and output back-pressure, and compares every result with a behavioral
// Q-format transform kept inside the bench.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC_BITS      = 16;
	localparam int ACC_W          = 72;    // roomy for four 64-bit products
	localparam int ITEMS_PER_SET  = 150;
	localparam int WATCHDOG_LIMIT = 2000;

	localparam logic signed [ACC_W-1:0] ROUND_HALF = 1 <<< (FRAC_BITS - 1);
	localparam logic signed [ACC_W-1:0] SAT_HI     = mvt_pkg::ELEM_MAX;
	localparam logic signed [ACC_W-1:0] SAT_LO     = mvt_pkg::ELEM_MIN;

	typedef enum logic [mvt_pkg::CFG_IDX_W-1:0] {
		COL0_ROWS01, COL0_ROWS23, COL1_ROWS01, COL1_ROWS23,
		COL2_ROWS01, COL2_ROWS23, COL3_ROWS01, COL3_ROWS23
	} mat_reg_e;

	typedef struct packed {
		mvt_pkg::elem_t x, y, z, w;
	} vector_t;

	typedef struct packed {
		mvt_pkg::elem_t x, y, z, w;
		logic           sat;
	} result_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	mvt_vec_if vec_ch ();
	mvt_res_if res_ch ();
	mvt_cfg_if cfg_ch ();

	matrix_vector_transform_core #(
		.FRAC_BITS(FRAC_BITS)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.vec   (vec_ch),
		.res   (res_ch),
		.cfg   (cfg_ch)
	);

	// bench copy of the matrix registers, updated on each in-range cfg transfer
	mvt_pkg::cfg_reg_t shadow_regs [mvt_pkg::NUM_REGS];

	vector_t vectors_to_send [$];
	result_t expected_results [$];
	int      mismatch_count = 0;

	// sender burst/gap and receiver stall state
	int burst_left = 0;
	int gap_left   = 0;
	int calm_left  = 0;
	int stall_left = 0;
	int idle_cycles = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// element of column col, row row
	function automatic mvt_pkg::elem_t matrix_elem(int col, int row);
		mvt_pkg::cfg_reg_t word;
		word = shadow_regs[col * 2 + row / 2];
		return (row % 2 == 1) ? word[mvt_pkg::REG_W-1:mvt_pkg::ELEM_W]
			: word[mvt_pkg::ELEM_W-1:0];
	endfunction

	// full-precision dot products, round half up, shift, clip to 32 bits
	function automatic result_t transform_vector(vector_t v);
		mvt_pkg::elem_t comp [mvt_pkg::DIM];
		mvt_pkg::elem_t row_out [mvt_pkg::DIM];
		logic signed [ACC_W-1:0] acc;
		result_t r_out;
		comp[0] = v.x;
		comp[1] = v.y;
		comp[2] = v.z;
		comp[3] = v.w;
		r_out.sat = 1'b0;
		for (int r = 0; r < mvt_pkg::DIM; r++) begin
			acc = ROUND_HALF;
			for (int j = 0; j < mvt_pkg::DIM; j++)
				acc += matrix_elem(j, r) * comp[j];
			acc = acc >>> FRAC_BITS;
			if (acc > SAT_HI) begin
				row_out[r] = mvt_pkg::ELEM_MAX;
				r_out.sat  = 1'b1;
			end else if (acc < SAT_LO) begin
				row_out[r] = mvt_pkg::ELEM_MIN;
				r_out.sat  = 1'b1;
			end else begin
				row_out[r] = acc[mvt_pkg::ELEM_W-1:0];
			end
		end
		r_out.x = row_out[0];
		r_out.y = row_out[1];
		r_out.z = row_out[2];
		r_out.w = row_out[3];
		return r_out;
	endfunction

	// mix of extremes, zero, values within +/- 2**span_bits and full-range patterns
	function automatic mvt_pkg::elem_t rand_elem(int unsigned span_bits);
		case ($urandom_range(0, 9))
			0: return mvt_pkg::ELEM_MAX;
			1: return mvt_pkg::ELEM_MIN;
			2: return '0;
			3, 4, 5: return mvt_pkg::elem_t'($urandom_range(0, 2 ** (span_bits + 1) - 1))
				- mvt_pkg::elem_t'(2 ** span_bits);
			default: return mvt_pkg::elem_t'($urandom());
		endcase
	endfunction

	function automatic void check_field(string field, logic [mvt_pkg::ELEM_W-1:0] want,
		logic [mvt_pkg::ELEM_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
			mismatch_count++;
		end
	endfunction

	function automatic void queue_vector(mvt_pkg::elem_t x, mvt_pkg::elem_t y,
		mvt_pkg::elem_t z, mvt_pkg::elem_t w);
		vector_t v;
		v.x = x;
		v.y = y;
		v.z = z;
		v.w = w;
		vectors_to_send.push_back(v);
	endfunction

	task automatic queue_random_vectors(int count);
		for (int i = 0; i < count; i++)
			queue_vector(rand_elem(24), rand_elem(24), rand_elem(24), rand_elem(24));
	endtask

	// leaves valid high so back-to-back writes need no extra assignment
	task automatic write_matrix_reg(logic [mvt_pkg::CFG_IDX_W-1:0] idx,
		mvt_pkg::cfg_reg_t value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		if (idx < mvt_pkg::NUM_REGS)
			shadow_regs[idx] = value;
	endtask

	// all eight registers, optionally followed by a write past the last index
	task automatic load_matrix(mvt_pkg::cfg_reg_t img [mvt_pkg::NUM_REGS], bit stray_write);
		for (int i = 0; i < mvt_pkg::NUM_REGS; i++)
			write_matrix_reg(mvt_pkg::CFG_IDX_W'(i), img[i]);
		if (stray_write)
			write_matrix_reg(mvt_pkg::CFG_IDX_W'($urandom_range(mvt_pkg::NUM_REGS,
				2 ** mvt_pkg::CFG_IDX_W - 1)), {$urandom(), $urandom()});
		cfg_ch.valid <= 1'b0;
	endtask

	// drain pipeline before touching the matrix
	task automatic wait_drained();
		while (vectors_to_send.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// vector driver: bursts of random length separated by random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			vec_ch.valid <= 1'b0;
		end else begin
			if (vec_ch.valid && vec_ch.ready)
				expected_results.push_back(transform_vector(vectors_to_send.pop_front()));
			// an offered vector is held until its transfer
			if (!vec_ch.valid || vec_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					vec_ch.valid <= 1'b0;
				end else if (vectors_to_send.size() != 0) begin
					vec_ch.valid <= 1'b1;
					vec_ch.in_x  <= vectors_to_send[0].x;
					vec_ch.in_y  <= vectors_to_send[0].y;
					vec_ch.in_z  <= vectors_to_send[0].z;
					vec_ch.in_w  <= vectors_to_send[0].w;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 40);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					vec_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stall pattern
	always @(posedge clk) begin
		result_t want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, got %h %h %h %h sat %b",
						$time, res_ch.out_x, res_ch.out_y, res_ch.out_z, res_ch.out_w,
						res_ch.saturated);
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("out_x", want.x, res_ch.out_x);
					check_field("out_y", want.y, res_ch.out_y);
					check_field("out_z", want.z, res_ch.out_z);
					check_field("out_w", want.w, res_ch.out_w);
					check_field("saturated", mvt_pkg::ELEM_W'(want.sat),
						mvt_pkg::ELEM_W'(res_ch.saturated));
				end
			end
			// calm stretches, short stalls, otherwise ready
			if (calm_left > 0) begin
				calm_left--;
				res_ch.ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				res_ch.ready <= 1'b0;
			end else begin
				case ($urandom_range(0, 9))
					0, 1: calm_left = $urandom_range(20, 100);
					2, 3, 4: stall_left = $urandom_range(1, 10);
					default: ;
				endcase
				res_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (vec_ch.valid && vec_ch.ready) || (res_ch.valid && res_ch.ready)
			|| (cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("matrix_vector_transform_core test failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		mvt_pkg::cfg_reg_t img [mvt_pkg::NUM_REGS];
		vec_ch.valid = 1'b0;
		vec_ch.in_x  = '0;
		vec_ch.in_y  = '0;
		vec_ch.in_z  = '0;
		vec_ch.in_w  = '0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data  = '0;

		// identity after reset
		shadow_regs[COL0_ROWS01] = 64'h0000_0000_0001_0000;
		shadow_regs[COL0_ROWS23] = '0;
		shadow_regs[COL1_ROWS01] = 64'h0001_0000_0000_0000;
		shadow_regs[COL1_ROWS23] = '0;
		shadow_regs[COL2_ROWS01] = '0;
		shadow_regs[COL2_ROWS23] = 64'h0000_0000_0001_0000;
		shadow_regs[COL3_ROWS01] = '0;
		shadow_regs[COL3_ROWS23] = 64'h0001_0000_0000_0000;

		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		// reset matrix passes vectors through
		queue_vector('0, '0, '0, '0);
		queue_vector(mvt_pkg::ELEM_MAX, mvt_pkg::ELEM_MAX, mvt_pkg::ELEM_MAX,
			mvt_pkg::ELEM_MAX);
		queue_vector(mvt_pkg::ELEM_MIN, mvt_pkg::ELEM_MIN, mvt_pkg::ELEM_MIN,
			mvt_pkg::ELEM_MIN);
		queue_vector(mvt_pkg::ELEM_MAX, mvt_pkg::ELEM_MIN, 32'sd1, -32'sd1);
		queue_vector(-32'sd1, 32'sd65536, -32'sd65536, 32'sd32768);
		queue_random_vectors(120);
		wait_drained();

		// every element at the minimum: largest sums, clipping both ways,
		// and a write past the last register that must leave the matrix alone
		for (int i = 0; i < mvt_pkg::NUM_REGS; i++)
			img[i] = {mvt_pkg::ELEM_MIN, mvt_pkg::ELEM_MIN};
		load_matrix(img, 1'b1);
		queue_vector(mvt_pkg::ELEM_MIN, mvt_pkg::ELEM_MIN, mvt_pkg::ELEM_MIN,
			mvt_pkg::ELEM_MIN);
		queue_vector(mvt_pkg::ELEM_MAX, mvt_pkg::ELEM_MAX, mvt_pkg::ELEM_MAX,
			mvt_pkg::ELEM_MAX);
		queue_vector('0, '0, '0, 32'sd1);
		queue_random_vectors(120);
		wait_drained();

		// every element at the maximum
		for (int i = 0; i < mvt_pkg::NUM_REGS; i++)
			img[i] = {mvt_pkg::ELEM_MAX, mvt_pkg::ELEM_MAX};
		load_matrix(img, 1'b0);
		queue_vector(mvt_pkg::ELEM_MAX, mvt_pkg::ELEM_MAX, mvt_pkg::ELEM_MAX,
			mvt_pkg::ELEM_MAX);
		queue_vector(mvt_pkg::ELEM_MIN, mvt_pkg::ELEM_MIN, mvt_pkg::ELEM_MIN,
			mvt_pkg::ELEM_MIN);
		queue_vector(mvt_pkg::ELEM_MAX, mvt_pkg::ELEM_MIN, mvt_pkg::ELEM_MAX,
			mvt_pkg::ELEM_MIN);
		queue_random_vectors(120);
		wait_drained();

		// diagonal of one half: ties round toward plus infinity
		for (int i = 0; i < mvt_pkg::NUM_REGS; i++)
			img[i] = '0;
		img[COL0_ROWS01] = 64'h0000_0000_0000_8000;
		img[COL1_ROWS01] = 64'h0000_8000_0000_0000;
		img[COL2_ROWS23] = 64'h0000_0000_0000_8000;
		img[COL3_ROWS23] = 64'h0000_8000_0000_0000;
		load_matrix(img, 1'b0);
		queue_vector(32'sd1, -32'sd1, 32'sd3, -32'sd3);
		queue_vector(mvt_pkg::ELEM_MAX, mvt_pkg::ELEM_MIN, -32'sd5, 32'sd5);
		queue_random_vectors(120);
		wait_drained();

		// random matrices
		for (int set = 0; set < 5; set++) begin
			for (int i = 0; i < mvt_pkg::NUM_REGS; i++)
				img[i] = {rand_elem(18), rand_elem(18)};
			load_matrix(img, 1'($urandom_range(0, 1)));
			queue_random_vectors(ITEMS_PER_SET);
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("matrix_vector_transform_core test passed");
		else
			$display("matrix_vector_transform_core test failed");
		$finish;
	end

endmodule

>>> matrix_vector_transform_core.f
src/mvt_pkg.sv
src/mvt_if.sv
src/mvt_cfg.sv
src/mvt_mul.sv
src/mvt_sum.sv
src/mvt_sat.sv
src/matrix_vector_transform_core.sv
verif/tb_top.sv
